[hdl/spq_pkg.sv]
// Shared definitions for the sorted priority queue: default sizes, action and
// status codes, sequencer states. Used by sorted_priority_queue.
// No dependencies.
`default_nettype none

package spq_pkg;

	// Default sizes, handed to the top level parameters
	localparam int DEF_CAPACITY     = 16;
	localparam int DEF_KEY_BITS     = 16;
	localparam int DEF_PAYLOAD_BITS = 32;

	// Requested operation
	typedef enum logic [1:0] {
		ACT_ENQ = 2'd0,
		ACT_DEQ = 2'd1,
		ACT_CLR = 2'd2,
		ACT_NOP = 2'd3   // unused code, no operation
	} action_t;

	// Result status
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_ENQ_RD  = 2'd1,
		ST_ENQ_CMP = 2'd2,
		ST_DEQ_RD  = 2'd3
	} state_t;

endpackage

`default_nettype wire

[hdl/spq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[hdl/sorted_priority_queue.sv]
// Sorted priority queue top level: sequencer, circular address unit, result registers.
// Depends on spq_pkg and spq_ram.
//
// Holds up to CAPACITY key/payload entries in ascending key order in one RAM used as
// a circular buffer; equal keys leave in arrival order. A command transfers at a
// rising edge with start high and busy low; its result is on the result ports for
// exactly one cycle with done high, in the cycle in which busy falls (or the cycle
// right after the transfer for commands that finish at once), and must be taken then.
// The insertion loop alternates ST_ENQ_RD, reading the entry below the insertion slot
// through the single RAM read port, and ST_ENQ_CMP, which compares it and moves it up
// one slot or writes the new entry; ST_ENQ_RD writes a new smallest key at the head.
// A dequeue waits in ST_DEQ_RD for the registered RAM read of the head entry. Clear,
// an enqueue into a full queue, a dequeue from an empty queue and the unused action
// code finish without going busy. Storage needs no clearing pass after reset.
`default_nettype none

module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY     = DEF_CAPACITY,
	parameter int KEY_BITS     = DEF_KEY_BITS,
	parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              action,
	input  wire logic [KEY_BITS-1:0]     key_in,
	input  wire logic [PAYLOAD_BITS-1:0] payload_in,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [KEY_BITS-1:0]          key_out,
	output logic [PAYLOAD_BITS-1:0]      payload_out,
	output logic                         is_empty
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = KEY_BITS + PAYLOAD_BITS;

	state_t                  state_q, state_d;
	logic [AW-1:0]           head_q, head_d;
	logic [CW-1:0]           count_q, count_d;
	logic [AW-1:0]           idx_q, idx_d;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] payload_q;

	logic                    done_q;
	status_t                 status_q;
	logic [KEY_BITS-1:0]     key_out_q;
	logic [PAYLOAD_BITS-1:0] payload_out_q;
	logic                    is_empty_q;

	logic                    accept;
	logic                    full;
	logic                    fin;
	status_t                 res_status;
	logic [KEY_BITS-1:0]     res_key;
	logic [PAYLOAD_BITS-1:0] res_payload;

	logic [AW-1:0]           offset;
	logic [AW:0]             sum;
	logic [AW-1:0]           phys;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [EW-1:0]           ram_wdata;
	logic                    ram_re;
	logic [EW-1:0]           ram_rdata;
	logic [KEY_BITS-1:0]     rd_key;
	logic [PAYLOAD_BITS-1:0] rd_payload;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign full       = (count_q == CW'(CAPACITY));
	assign rd_key     = ram_rdata[EW-1:PAYLOAD_BITS];
	assign rd_payload = ram_rdata[PAYLOAD_BITS-1:0];

	// Shared address unit: logical slot to RAM address, head plus offset modulo capacity
	always_comb begin
		case (state_q)
			ST_ENQ_RD:  offset = (idx_q != '0) ? (idx_q - AW'(1)) : '0;
			ST_ENQ_CMP: offset = idx_q;
			ST_DEQ_RD:  offset = AW'(1);
			default:    offset = '0;
		endcase
		sum = {1'b0, head_q} + {1'b0, offset};
		if (sum >= (AW + 1)'(CAPACITY)) begin
			phys = AW'(sum - (AW + 1)'(CAPACITY));
		end else begin
			phys = sum[AW-1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_ENQ: if (!full) state_d = ST_ENQ_RD;
						ACT_DEQ: if (count_q != '0) state_d = ST_DEQ_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ENQ_RD: begin
				if (idx_q != '0) state_d = ST_ENQ_CMP;
				else state_d = ST_IDLE;
			end
			ST_ENQ_CMP: begin
				if (rd_key > key_q) state_d = ST_ENQ_RD;
				else state_d = ST_IDLE;
			end
			ST_DEQ_RD: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Datapath control and results
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = phys;
		ram_wdata   = {key_q, payload_q};
		ram_re      = 1'b0;
		head_d      = head_q;
		count_d     = count_q;
		idx_d       = idx_q;
		fin         = 1'b0;
		res_status  = STAT_OK;
		res_key     = '0;
		res_payload = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_ENQ: begin
							if (full) begin
								fin        = 1'b1;
								res_status = STAT_FULL;
							end else begin
								idx_d = count_q[AW-1:0];
							end
						end
						ACT_DEQ: begin
							if (count_q == '0) begin
								fin        = 1'b1;
								res_status = STAT_EMPTY;
							end else begin
								// offset is zero here: read the head entry
								ram_re = 1'b1;
							end
						end
						ACT_CLR: begin
							count_d = '0;
							fin     = 1'b1;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			ST_ENQ_RD: begin
				if (idx_q != '0) begin
					ram_re = 1'b1;
				end else begin
					// new key is the smallest: lands at the head slot
					ram_we  = 1'b1;
					count_d = count_q + CW'(1);
					fin     = 1'b1;
				end
			end
			ST_ENQ_CMP: begin
				ram_we = 1'b1;
				if (rd_key > key_q) begin
					// move the larger entry up one slot
					ram_wdata = ram_rdata;
					idx_d     = idx_q - AW'(1);
				end else begin
					count_d = count_q + CW'(1);
					fin     = 1'b1;
				end
			end
			ST_DEQ_RD: begin
				res_key     = rd_key;
				res_payload = rd_payload;
				head_d      = phys;
				count_d     = count_q - CW'(1);
				fin         = 1'b1;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			done_q  <= fin;
		end
	end

	// Command capture and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= key_in;
			payload_q <= payload_in;
		end
		if (fin) begin
			status_q      <= res_status;
			key_out_q     <= res_key;
			payload_out_q <= res_payload;
			is_empty_q    <= (count_d == '0);
		end
	end

	spq_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(phys),
		.rd_data(ram_rdata)
	);

	assign done        = done_q;
	assign status      = status_q;
	assign key_out     = key_out_q;
	assign payload_out = payload_out_q;
	assign is_empty    = is_empty_q;

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while sequencer busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_cmd_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done_q))
		else $error("command transfer neither busy nor finished");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == STAT_FULL)) |-> (count_q == CW'(CAPACITY)))
		else $error("enqueue rejected while queue not full");

endmodule

`default_nettype wire

[tb/sv/spq_result_checker.sv]
// Result checker for the sorted priority queue: watches command and result
// transfers, keeps its own sorted copy of the queue and compares every result.
// Depends on spq_pkg.
`default_nettype none

module spq_result_checker
	import spq_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic [1:0]                  action,
	input  wire logic [DEF_KEY_BITS-1:0]     key_in,
	input  wire logic [DEF_PAYLOAD_BITS-1:0] payload_in,
	input  wire logic                        done,
	input  wire logic [1:0]                  status,
	input  wire logic [DEF_KEY_BITS-1:0]     key_out,
	input  wire logic [DEF_PAYLOAD_BITS-1:0] payload_out,
	input  wire logic                        is_empty,
	output int                               mismatches,
	output int                               results_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t                     status;
		logic [DEF_KEY_BITS-1:0]     key;
		logic [DEF_PAYLOAD_BITS-1:0] payload;
		logic                        empty;
	} queue_result_t;

	// Sorted copy of the queue contents
	logic [DEF_KEY_BITS-1:0]     sorted_keys [DEF_CAPACITY];
	logic [DEF_PAYLOAD_BITS-1:0] sorted_payloads [DEF_CAPACITY];
	int                          stored_count;

	// Results owed by the block, oldest first
	queue_result_t results_due [$];

	initial begin
		mismatches = 0;
		results_outstanding = 0;
		stored_count = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Carry out one command on the local copy and return the result it owes
	function automatic queue_result_t apply_command(
		input logic [1:0]                  act,
		input logic [DEF_KEY_BITS-1:0]     k,
		input logic [DEF_PAYLOAD_BITS-1:0] p
	);
		queue_result_t r;
		int pos;
		int i;
		r.status = STAT_OK;
		r.key = '0;
		r.payload = '0;
		case (act)
			ACT_ENQ: begin
				if (stored_count >= DEF_CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					// new entry goes behind all keys less than or equal to it
					pos = 0;
					while (pos < stored_count && sorted_keys[pos] <= k)
						pos++;
					for (i = stored_count; i > pos; i--) begin
						sorted_keys[i] = sorted_keys[i-1];
						sorted_payloads[i] = sorted_payloads[i-1];
					end
					sorted_keys[pos] = k;
					sorted_payloads[pos] = p;
					stored_count++;
				end
			end
			ACT_DEQ: begin
				if (stored_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.key = sorted_keys[0];
					r.payload = sorted_payloads[0];
					for (i = 1; i < stored_count; i++) begin
						sorted_keys[i-1] = sorted_keys[i];
						sorted_payloads[i-1] = sorted_payloads[i];
					end
					stored_count--;
				end
			end
			ACT_CLR: begin
				stored_count = 0;
			end
			default: ;  // unused code: nothing changes
		endcase
		r.empty = (stored_count == 0);
		return r;
	endfunction

	// Result check first (it belongs to an earlier command), then new command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count = 0;
			results_due.delete();
		end else begin
			if (done) begin
				if (results_due.size() == 0) begin
					report_mismatch("result with no command waiting");
				end else begin
					queue_result_t want;
					want = results_due.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d", status, want.status));
					if (key_out !== want.key)
						report_mismatch($sformatf("key_out %h, want %h", key_out, want.key));
					if (payload_out !== want.payload)
						report_mismatch($sformatf("payload_out %h, want %h",
							payload_out, want.payload));
					if (is_empty !== want.empty)
						report_mismatch($sformatf("is_empty %b, want %b", is_empty, want.empty));
				end
			end
			if (start && !busy)
				results_due.push_back(apply_command(action, key_in, payload_in));
		end
		results_outstanding = results_due.size();
	end

endmodule

`default_nettype wire

[tb/sv/sorted_priority_queue_tb.sv]
// Testbench top for the sorted priority queue: clock, reset, directed and
// random command stimulus, final verdict.
// Depends on spq_pkg, sorted_priority_queue and spq_result_checker.
`default_nettype none

module sorted_priority_queue_tb;
	import spq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic [1:0]                  action = ACT_ENQ;
	logic [DEF_KEY_BITS-1:0]     key_in = '0;
	logic [DEF_PAYLOAD_BITS-1:0] payload_in = '0;
	logic                        busy;
	logic                        done;
	logic [1:0]                  status;
	logic [DEF_KEY_BITS-1:0]     key_out;
	logic [DEF_PAYLOAD_BITS-1:0] payload_out;
	logic                        is_empty;
	int                          mismatches;
	int                          results_outstanding;
	bit                          no_gaps = 1'b0;

	sorted_priority_queue uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .key_in(key_in), .payload_in(payload_in),
		.done(done), .status(status), .key_out(key_out),
		.payload_out(payload_out), .is_empty(is_empty)
	);

	spq_result_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .key_in(key_in), .payload_in(payload_in),
		.done(done), .status(status), .key_out(key_out),
		.payload_out(payload_out), .is_empty(is_empty),
		.mismatches(mismatches), .results_outstanding(results_outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Present one command and hold it until the transfer
	task automatic issue(
		input logic [1:0]                  act,
		input logic [DEF_KEY_BITS-1:0]     k,
		input logic [DEF_PAYLOAD_BITS-1:0] p
	);
		start <= 1'b1;
		action <= act;
		key_in <= k;
		payload_in <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Random gap after a transfer
	task automatic maybe_idle();
		int gap;
		if (!no_gaps && $urandom_range(0, 99) < 32) begin
			gap = $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [DEF_KEY_BITS-1:0] pick_key();
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 4)
			return DEF_KEY_BITS'($urandom_range(0, 3));  // many ties
		else if (mode < 8)
			return DEF_KEY_BITS'($urandom);
		else if (mode == 8)
			return $urandom_range(0, 1) ? '1 : '0;
		else
			return DEF_KEY_BITS'(16'h7ffe + $urandom_range(0, 3));
	endfunction

	function automatic logic [DEF_PAYLOAD_BITS-1:0] pick_payload();
		int mode;
		mode = $urandom_range(0, 19);
		if (mode == 0)
			return '0;
		else if (mode == 1)
			return '1;
		return DEF_PAYLOAD_BITS'($urandom);
	endfunction

	initial begin
		int roll;
		int enq_pct;
		int deq_pct;
		logic [1:0] act;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty cases, unused code, extremes, ties, full queue
		issue(ACT_DEQ, '1, '1);
		issue(ACT_CLR, '0, '0);
		issue(ACT_NOP, '1, '1);
		issue(ACT_ENQ, '1, '1);
		issue(ACT_ENQ, '0, '0);
		issue(ACT_ENQ, 16'h0005, 32'hAAAA_5555);
		issue(ACT_ENQ, 16'h0005, 32'h5555_AAAA);
		for (int j = 0; j < 12; j++) begin
			case (j % 3)
				0: issue(ACT_ENQ, 16'h0005, pick_payload());
				1: issue(ACT_ENQ, 16'h8000, pick_payload());
				default: issue(ACT_ENQ, pick_key(), pick_payload());
			endcase
			maybe_idle();
		end
		issue(ACT_ENQ, 16'h0001, 32'hDEAD_BEEF);  // full: rejected
		issue(ACT_NOP, '0, '0);
		issue(ACT_DEQ, '0, '0);
		issue(ACT_DEQ, '0, '0);
		issue(ACT_CLR, '1, '1);
		issue(ACT_DEQ, '0, '0);

		// Random: phases that fill, drain and churn the queue
		for (int n = 0; n < 750; n++) begin
			no_gaps = (n >= 300 && n < 420);
			case ((n / 60) % 4)
				0: begin enq_pct = 75; deq_pct = 20; end
				1: begin enq_pct = 25; deq_pct = 70; end
				2: begin enq_pct = 50; deq_pct = 45; end
				default: begin enq_pct = 88; deq_pct = 9; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < enq_pct)
				act = ACT_ENQ;
			else if (roll < enq_pct + deq_pct)
				act = ACT_DEQ;
			else if (roll < 99)
				act = ACT_CLR;
			else
				act = ACT_NOP;
			issue(act, pick_key(), pick_payload());
			maybe_idle();
		end
		start <= 1'b0;

		// Drain, then allow for the longest insertion
		while (results_outstanding != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
